// ===== rtl/lpct_pkg.sv =====
`timescale 1ns / 1ps

package lpct_pkg;

  // default count width
  localparam int COUNT_WIDTH = 16;

  // stream and port widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int REG_DATA_W  = 16;
  localparam int ADDR_W      = 3;
  localparam int CODE_W      = 4;
  localparam int PRESCALE_W  = 16;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [ADDR_W-1:0] {
    ADDR_CONTROL = 3'd0,
    ADDR_STATUS  = 3'd1,
    ADDR_IRQ_EN  = 3'd2,
    ADDR_COMPARE = 3'd3,
    ADDR_LATCH   = 3'd4,
    ADDR_COUNT   = 3'd5
  } addr_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PRESCALE_CODE = 2'd0,
    CFG_PRESCALE_BYP  = 2'd1,
    CFG_FREE_RUNNING  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [ADDR_W-1:0]     reg_address;
    logic [REG_DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0] prescale_code;
    logic              prescale_bypass;
    logic              free_running;
  } cfg_t;

  typedef struct packed {
    logic [REG_DATA_W-1:0] read_data;
    logic                  irq;
  } result_t;

  // terminal prescaler value, 2^(code+1) - 1
  function automatic logic [PRESCALE_W-1:0] prescale_last(input logic [CODE_W-1:0] code);
    logic [CODE_W:0] sh;
    begin
      sh = {1'b0, code} + (CODE_W+1)'(1);
      return ~({PRESCALE_W{1'b1}} << sh);
    end
  endfunction

endpackage

// ===== rtl/lpct_core.sv =====
`timescale 1ns / 1ps

module lpct_core #(
  parameter int COUNT_WIDTH = lpct_pkg::COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  lpct_pkg::item_t   item,
  input  lpct_pkg::cfg_t    cfg,
  output lpct_pkg::result_t res
);

  logic [COUNT_WIDTH-1:0]          count_value, count_value_next;
  logic [COUNT_WIDTH-1:0]          compare_value, compare_value_next;
  logic [COUNT_WIDTH-1:0]          latched_count, latched_count_next;
  logic [lpct_pkg::PRESCALE_W-1:0] prescale_count, prescale_count_next;
  logic                            timer_enabled, timer_enabled_next;
  logic                            match_flag, match_flag_next;
  logic                            irq_enabled, irq_enabled_next;
  logic                            advance;
  logic                            match;
  logic [lpct_pkg::REG_DATA_W-1:0] read_data;

  assign match = (count_value == compare_value);

  always_comb begin
    count_value_next    = count_value;
    compare_value_next  = compare_value;
    latched_count_next  = latched_count;
    prescale_count_next = prescale_count;
    timer_enabled_next  = timer_enabled;
    match_flag_next     = match_flag;
    irq_enabled_next    = irq_enabled;
    advance             = 1'b0;
    read_data           = '0;
    if (step) begin
      unique case (item.mode)
        lpct_pkg::MODE_TICK: begin
          if (timer_enabled) begin
            if (cfg.prescale_bypass) begin
              advance = 1'b1;
            end else if (prescale_count >= lpct_pkg::prescale_last(cfg.prescale_code)) begin
              // a lowered code makes an overshot prescaler terminal at once
              prescale_count_next = '0;
              advance             = 1'b1;
            end else begin
              prescale_count_next = prescale_count + 1'b1;
            end
          end
        end
        lpct_pkg::MODE_WRITE: begin
          unique case (item.reg_address)
            lpct_pkg::ADDR_CONTROL: begin
              timer_enabled_next = item.write_data[0];
              if (!item.write_data[0]) begin
                count_value_next    = '0;
                prescale_count_next = '0;
              end
            end
            lpct_pkg::ADDR_STATUS: begin
              if (item.write_data[0]) match_flag_next = 1'b0;
            end
            lpct_pkg::ADDR_IRQ_EN:  irq_enabled_next   = item.write_data[0];
            lpct_pkg::ADDR_COMPARE: compare_value_next = COUNT_WIDTH'(item.write_data);
            lpct_pkg::ADDR_LATCH:   latched_count_next = count_value;
            default: ;
          endcase
        end
        lpct_pkg::MODE_READ: begin
          unique case (item.reg_address)
            lpct_pkg::ADDR_CONTROL: read_data = lpct_pkg::REG_DATA_W'(timer_enabled);
            lpct_pkg::ADDR_STATUS:  read_data = lpct_pkg::REG_DATA_W'(match_flag);
            lpct_pkg::ADDR_IRQ_EN:  read_data = lpct_pkg::REG_DATA_W'(irq_enabled);
            lpct_pkg::ADDR_COMPARE: read_data = lpct_pkg::REG_DATA_W'(compare_value);
            lpct_pkg::ADDR_COUNT:   read_data = lpct_pkg::REG_DATA_W'(latched_count);
            default:                read_data = '0;
          endcase
        end
        default: ;
      endcase
    end
    if (advance) begin
      if (match) match_flag_next = 1'b1;
      // restart mode returns to zero on a match, otherwise wrap at maximum
      if (match && !cfg.free_running) begin
        count_value_next = '0;
      end else begin
        count_value_next = count_value + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value    <= '0;
      compare_value  <= '0;
      latched_count  <= '0;
      prescale_count <= '0;
      timer_enabled  <= 1'b0;
      match_flag     <= 1'b0;
      irq_enabled    <= 1'b0;
    end else begin
      count_value    <= count_value_next;
      compare_value  <= compare_value_next;
      latched_count  <= latched_count_next;
      prescale_count <= prescale_count_next;
      timer_enabled  <= timer_enabled_next;
      match_flag     <= match_flag_next;
      irq_enabled    <= irq_enabled_next;
    end
  end

  assign res.read_data = read_data;
  assign res.irq       = irq_enabled_next & match_flag_next;

endmodule

// ===== rtl/low_power_compare_timer_top.sv =====
`timescale 1ns / 1ps
// path: an accepted request is held in the input register, its result in the result register on the master side
// throughput: one request per cycle while the master side accepts results; the single state-update stage sets this
// an input register and an output register decouple the two sides
// reset: synchronous, active high; clears timer state, config and both valid flags

module low_power_compare_timer_top #(
  parameter int COUNT_WIDTH = lpct_pkg::COUNT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] reg_address, [18:3] write_data, [23:19] zero
  input  logic [lpct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [lpct_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] read_data, [16] irq, [23:17] zero
  output logic [lpct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [lpct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpct_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lpct_pkg::cfg_t    cfg;
  lpct_pkg::item_t   item;
  lpct_pkg::result_t res;
  lpct_pkg::result_t out_res;
  logic              item_valid;
  logic              out_valid;
  logic              advance;

  assign advance       = item_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpct_pkg::CFG_PRESCALE_CODE: cfg.prescale_code   <= cfg_data[lpct_pkg::CODE_W-1:0];
        lpct_pkg::CFG_PRESCALE_BYP:  cfg.prescale_bypass <= cfg_data[0];
        lpct_pkg::CFG_FREE_RUNNING:  cfg.free_running    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.mode        <= s_axis_tuser[1:0];
      item.reg_address <= s_axis_tdata[lpct_pkg::ADDR_W-1:0];
      item.write_data  <= s_axis_tdata[lpct_pkg::ADDR_W +: lpct_pkg::REG_DATA_W];
    end
  end

  lpct_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(lpct_pkg::OUT_TDATA_W-lpct_pkg::REG_DATA_W-1){1'b0}},
                          out_res.irq, out_res.read_data};

endmodule

// ===== rtl/lpct_checker.sv =====
`timescale 1ns / 1ps

module lpct_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [lpct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [lpct_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lpct_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic s_req;
  assign s_req = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // an empty output side never stalls the input
  a_ready_when_empty: assert property (@(posedge clk)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // irq enable written to zero gives irq low on its result
  a_irq_off: assert property (@(posedge clk) disable iff (rst)
    (s_req && s_axis_tuser == lpct_pkg::MODE_WRITE
     && s_axis_tdata[2:0] == lpct_pkg::ADDR_IRQ_EN && !s_axis_tdata[3])
    ##1 m_axis_tready |=> m_axis_tvalid && !m_axis_tdata[16])
    else $error("irq high after irq enable cleared");

  // the latch register reads zero
  a_latch_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (s_req && s_axis_tuser == lpct_pkg::MODE_READ
     && s_axis_tdata[2:0] == lpct_pkg::ADDR_LATCH)
    ##1 m_axis_tready |=> m_axis_tvalid && m_axis_tdata[15:0] == 16'd0)
    else $error("latch read not zero");

endmodule

bind low_power_compare_timer_top lpct_checker u_lpct_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
